// ===== rtl/cre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cre_pkg;

    localparam int CHANNELS    = 4;
    localparam int MAX_REPLIES = 8;

    localparam int OP_W    = 2;
    localparam int CHF_W   = 2;
    localparam int ID_W    = 5;
    localparam int DATA_W  = 8;
    localparam int EXP_W   = 4;
    localparam int FRAME_W = 32;
    localparam int TX_W    = 13;
    localparam int ST_W    = 2;
    localparam int ERR_W   = 8;
    localparam int SLOTF_W = 3;

    localparam int PARITY_POS = 22;
    localparam int VALID_POS  = 16;
    localparam int DATA_SHIFT = 5;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = (MAX_REPLIES > 1) ? $clog2(MAX_REPLIES) : 1;
    localparam int CNT_W  = $clog2(MAX_REPLIES + 1);
    localparam int DEPTH  = CHANNELS * MAX_REPLIES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FENT_W = DATA_W + 1;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = OP_W + CHF_W;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 1 + CHF_W;
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;

    localparam logic [PADDR_W-1:0] REG_RETRY_LIMIT = 2'd0;
    localparam logic [ERR_W-1:0]   RETRY_RESET     = 8'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FRAME   = 2'd1;
    localparam logic [ST_W-1:0] ST_TIMEOUT = 2'd2;

    localparam logic KIND_CMD = 1'b0;
    localparam logic KIND_RPT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_START   = 2'd0,
        OP_SENT    = 2'd1,
        OP_REPLY   = 2'd2,
        OP_TIMEOUT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TX   = 2'd1,
        PH_RX   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHK_RD,
        S_CHK_EV,
        S_SEND,
        S_RPT_RD,
        S_RPT_OUT
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [CHF_W-1:0]   ch;
        logic [ID_W-1:0]    id;
        logic [DATA_W-1:0]  data;
        logic [EXP_W-1:0]   exp;
        logic               frm_ok;
        logic [DATA_W-1:0]  frm_byte;
    } t_item;

    typedef struct packed {
        logic                frm_we;
        logic                frm_re;
        logic                dat_we;
        logic                dat_re;
        logic [ADDR_W-1:0]   addr;
        logic [FENT_W-1:0]   frm_wdata;
        logic [DATA_W-1:0]   dat_wdata;
    } t_mem_req;

    typedef struct packed {
        logic               frm_ok;
        logic [DATA_W-1:0]  frm_byte;
        logic [DATA_W-1:0]  dat_byte;
    } t_mem_rsp;

    typedef struct packed {
        logic                kind;
        logic [CHF_W-1:0]    ch;
        logic [TX_W-1:0]     tx_frame;
        logic [ST_W-1:0]     status;
        logic [DATA_W-1:0]   reply_byte;
        logic [SLOTF_W-1:0]  slot;
        logic                last;
    } t_result;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_W-1:0] ch,
                                                   input logic [SLOT_W-1:0] k);
        return ADDR_W'(32'(ch) * MAX_REPLIES + 32'(k));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/command_response_retry_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | handshake               | payload
// s_axis    | in  | tvalid/tready           | tuser: op, channel; tdata: id, data, exp, frame
// m_axis    | out | tvalid/tready, tlast    | tuser: kind, channel; tdata: frame, status, byte, slot
// apb       | in  | psel/penable, pready=1  | retry_limit at byte address 0
//
// a start passes the idle, exec and send states to its command frame; an unarmed or arming event
// returns to idle after exec; a completing reply reads and checks each stored frame, then reads and
// sends each report entry, one step at a time on the shared slot counter and one port per store
// reset is synchronous; it clears the per-channel state and the data store valid bits
// a stall on m_axis holds the sequencer; no new request is taken until the event is done

module command_response_retry_engine (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // cmd_id, cmd_data, expected_replies, reply_frame
    input  wire [cre_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op, channel
    input  wire [cre_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // tx_frame, status, reply_byte, slot
    output logic [cre_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // kind, out_channel
    output logic [cre_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tlast,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [cre_pkg::PADDR_W-1:0]        paddr,
    input  wire [cre_pkg::PDATA_W-1:0]        pwdata,
    output logic [cre_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [cre_pkg::ERR_W-1:0] r_retry_limit;
    logic                      r_out_valid;
    cre_pkg::t_result          r_out;

    cre_pkg::t_item            item;
    cre_pkg::t_mem_req         mem_req;
    cre_pkg::t_mem_rsp         mem_rsp;
    cre_pkg::t_result          res;
    logic                      res_valid;
    logic                      res_ready;
    logic [cre_pkg::FRAME_W-1:0] frame;

    always_comb begin
        frame         = s_axis_tdata[48:17];
        item.op       = cre_pkg::t_op'(s_axis_tuser[1:0]);
        item.ch       = s_axis_tuser[3:2];
        item.id       = s_axis_tdata[4:0];
        item.data     = s_axis_tdata[12:5];
        item.exp      = s_axis_tdata[16:13];
        item.frm_ok   = !frame[cre_pkg::PARITY_POS] && frame[cre_pkg::VALID_POS];
        item.frm_byte = frame[cre_pkg::DATA_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == cre_pkg::REG_RETRY_LIMIT)
                    ? cre_pkg::PDATA_W'(r_retry_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= cre_pkg::RETRY_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == cre_pkg::REG_RETRY_LIMIT)) begin
            r_retry_limit <= pwdata[cre_pkg::ERR_W-1:0];
        end
    end

    cre_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (s_axis_tvalid),
        .o_item_ready  (s_axis_tready),
        .i_item        (item),
        .i_retry_limit (r_retry_limit),
        .o_mem_req     (mem_req),
        .i_mem_rsp     (mem_rsp),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    cre_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    // output register
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = {r_out.ch, r_out.kind};
    assign m_axis_tdata  = {6'd0, r_out.slot, r_out.reply_byte, r_out.status, r_out.tx_frame};

endmodule

`default_nettype wire

// ===== rtl/cre_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cre_mem (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  cre_pkg::t_mem_req        i_req,
    output cre_pkg::t_mem_rsp        o_rsp
);

    logic [cre_pkg::FENT_W-1:0] r_frm_mem [cre_pkg::DEPTH];
    logic [cre_pkg::DATA_W-1:0] r_dat_mem [cre_pkg::DEPTH];
    logic [cre_pkg::DEPTH-1:0]  r_dat_vld;
    logic [cre_pkg::FENT_W-1:0] r_frm_q;
    logic [cre_pkg::DATA_W-1:0] r_dat_q;
    logic                       r_dat_vq;

    // frame store: ok flag and data byte per slot
    always_ff @(posedge i_clk) begin
        if (i_req.frm_we) begin
            r_frm_mem[i_req.addr] <= i_req.frm_wdata;
        end
        if (i_req.frm_re) begin
            r_frm_q <= r_frm_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.dat_we) begin
            r_dat_mem[i_req.addr] <= i_req.dat_wdata;
        end
        if (i_req.dat_re) begin
            r_dat_q  <= r_dat_mem[i_req.addr];
            r_dat_vq <= r_dat_vld[i_req.addr];
        end
    end

    // unwritten data slots read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dat_vld <= '0;
        end else if (i_req.dat_we) begin
            r_dat_vld[i_req.addr] <= 1'b1;
        end
    end

    assign o_rsp.frm_ok   = r_frm_q[cre_pkg::DATA_W];
    assign o_rsp.frm_byte = r_frm_q[cre_pkg::DATA_W-1:0];
    assign o_rsp.dat_byte = r_dat_vq ? r_dat_q : '0;

endmodule

`default_nettype wire

// ===== rtl/cre_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cre_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_item_valid,
    output logic                         o_item_ready,
    input  cre_pkg::t_item               i_item,
    input  wire [cre_pkg::ERR_W-1:0]     i_retry_limit,
    output cre_pkg::t_mem_req            o_mem_req,
    input  cre_pkg::t_mem_rsp            i_mem_rsp,
    output logic                         o_res_valid,
    input  wire                          i_res_ready,
    output cre_pkg::t_result             o_res
);

    cre_pkg::t_state                r_state, n_state;
    cre_pkg::t_item                 r_item;
    logic [cre_pkg::CNT_W-1:0]      r_k;
    logic [cre_pkg::ST_W-1:0]       r_status;

    logic [cre_pkg::ID_W-1:0]       r_sid   [cre_pkg::CHANNELS];
    logic [cre_pkg::DATA_W-1:0]     r_sdata [cre_pkg::CHANNELS];
    logic [cre_pkg::EXP_W-1:0]      r_sexp  [cre_pkg::CHANNELS];
    logic [cre_pkg::CNT_W-1:0]      r_rc    [cre_pkg::CHANNELS];
    logic [cre_pkg::ERR_W-1:0]      r_err   [cre_pkg::CHANNELS];
    cre_pkg::t_phase                r_phase [cre_pkg::CHANNELS];

    logic [cre_pkg::CH_W-1:0]       ch_idx;
    logic                           ch_ok;
    cre_pkg::t_phase                cur_phase;
    logic [cre_pkg::EXP_W-1:0]      cur_exp;
    logic [cre_pkg::CNT_W-1:0]      cur_rc;
    logic [cre_pkg::ERR_W-1:0]      err_inc;
    logic [cre_pkg::EXP_W-1:0]      exp_sat;
    logic [cre_pkg::CNT_W-1:0]      rpt_n;
    logic [cre_pkg::CNT_W-1:0]      k_inc;
    logic [cre_pkg::CNT_W-1:0]      rc_after;
    logic                           give_up;
    logic                           exec_start;
    logic                           exec_sent_rpt;
    logic                           exec_sent_arm;
    logic                           exec_reply;
    logic                           reply_store;
    logic                           reply_full;
    logic                           exec_timeout;
    logic                           chk_bad;
    logic                           chk_done_ok;
    logic                           fail_now;
    logic                           fail_report;
    logic                           fail_resend;
    logic                           ok_report;
    logic                           rpt_last;

    // event decode against the channel's saved state
    always_comb begin
        ch_idx    = cre_pkg::CH_W'(r_item.ch);
        ch_ok     = 32'(r_item.ch) < 32'(cre_pkg::CHANNELS);
        cur_phase = r_phase[ch_idx];
        cur_exp   = r_sexp[ch_idx];
        cur_rc    = r_rc[ch_idx];
        err_inc   = r_err[ch_idx] + cre_pkg::ERR_W'(1);
        give_up   = err_inc > i_retry_limit;
        exp_sat   = (32'(r_item.exp) > cre_pkg::MAX_REPLIES)
                    ? cre_pkg::EXP_W'(cre_pkg::MAX_REPLIES) : r_item.exp;
        rpt_n     = (cur_exp == '0) ? cre_pkg::CNT_W'(1) : cre_pkg::CNT_W'(cur_exp);
        k_inc     = r_k + cre_pkg::CNT_W'(1);
        rpt_last  = (k_inc == rpt_n);

        exec_start    = (r_state == cre_pkg::S_EXEC) && ch_ok
                        && (r_item.op == cre_pkg::OP_START);
        exec_sent_rpt = (r_state == cre_pkg::S_EXEC) && ch_ok
                        && (r_item.op == cre_pkg::OP_SENT)
                        && (cur_phase == cre_pkg::PH_TX) && (cur_exp == '0);
        exec_sent_arm = (r_state == cre_pkg::S_EXEC) && ch_ok
                        && (r_item.op == cre_pkg::OP_SENT)
                        && (cur_phase == cre_pkg::PH_TX) && (cur_exp != '0);
        exec_reply    = (r_state == cre_pkg::S_EXEC) && ch_ok
                        && (r_item.op == cre_pkg::OP_REPLY)
                        && (cur_phase == cre_pkg::PH_RX);
        reply_store   = exec_reply && (cur_rc < cre_pkg::CNT_W'(cur_exp));
        rc_after      = reply_store ? (cur_rc + cre_pkg::CNT_W'(1)) : cur_rc;
        reply_full    = exec_reply && (rc_after == cre_pkg::CNT_W'(cur_exp));
        exec_timeout  = (r_state == cre_pkg::S_EXEC) && ch_ok
                        && (r_item.op == cre_pkg::OP_TIMEOUT)
                        && (cur_phase != cre_pkg::PH_IDLE);
        chk_bad       = (r_state == cre_pkg::S_CHK_EV) && !i_mem_rsp.frm_ok;
        chk_done_ok   = (r_state == cre_pkg::S_CHK_EV) && i_mem_rsp.frm_ok
                        && (k_inc == cre_pkg::CNT_W'(cur_exp));
        fail_now      = exec_timeout || chk_bad;
        fail_report   = fail_now && give_up;
        fail_resend   = fail_now && !give_up;
        ok_report     = exec_sent_rpt || chk_done_ok;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cre_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    n_state = cre_pkg::S_EXEC;
                end
            end
            cre_pkg::S_EXEC: begin
                if (exec_start || fail_resend) begin
                    n_state = cre_pkg::S_SEND;
                end else if (ok_report || fail_report) begin
                    n_state = cre_pkg::S_RPT_RD;
                end else if (reply_full) begin
                    n_state = cre_pkg::S_CHK_RD;
                end else begin
                    n_state = cre_pkg::S_IDLE;
                end
            end
            cre_pkg::S_CHK_RD: begin
                n_state = cre_pkg::S_CHK_EV;
            end
            cre_pkg::S_CHK_EV: begin
                if (fail_resend) begin
                    n_state = cre_pkg::S_SEND;
                end else if (fail_report || ok_report) begin
                    n_state = cre_pkg::S_RPT_RD;
                end else begin
                    n_state = cre_pkg::S_CHK_RD;
                end
            end
            cre_pkg::S_SEND: begin
                if (i_res_ready) begin
                    n_state = cre_pkg::S_IDLE;
                end
            end
            cre_pkg::S_RPT_RD: begin
                n_state = cre_pkg::S_RPT_OUT;
            end
            cre_pkg::S_RPT_OUT: begin
                if (i_res_ready) begin
                    n_state = rpt_last ? cre_pkg::S_IDLE : cre_pkg::S_RPT_RD;
                end
            end
            default: begin
                n_state = cre_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_mem_req    = '0;
        o_res        = '0;
        o_mem_req.addr = cre_pkg::mem_addr(ch_idx, cre_pkg::SLOT_W'(r_k));
        unique case (r_state)
            cre_pkg::S_IDLE: begin
                o_item_ready = 1'b1;
            end
            cre_pkg::S_EXEC: begin
                o_mem_req.frm_we    = reply_store;
                o_mem_req.addr      = cre_pkg::mem_addr(ch_idx, cre_pkg::SLOT_W'(cur_rc));
                o_mem_req.frm_wdata = {r_item.frm_ok, r_item.frm_byte};
            end
            cre_pkg::S_CHK_RD: begin
                o_mem_req.frm_re = 1'b1;
            end
            cre_pkg::S_CHK_EV: begin
                o_mem_req.dat_we    = 1'b1;
                o_mem_req.dat_wdata = i_mem_rsp.frm_byte;
            end
            cre_pkg::S_SEND: begin
                o_res_valid    = 1'b1;
                o_res.kind     = cre_pkg::KIND_CMD;
                o_res.ch       = r_item.ch;
                o_res.tx_frame = (cre_pkg::TX_W'(r_sdata[ch_idx]) << cre_pkg::DATA_SHIFT)
                                 | cre_pkg::TX_W'(r_sid[ch_idx]);
                o_res.last     = 1'b1;
            end
            cre_pkg::S_RPT_RD: begin
                o_mem_req.dat_re = 1'b1;
            end
            cre_pkg::S_RPT_OUT: begin
                o_res_valid      = 1'b1;
                o_res.kind       = cre_pkg::KIND_RPT;
                o_res.ch         = r_item.ch;
                o_res.status     = r_status;
                o_res.reply_byte = i_mem_rsp.dat_byte;
                o_res.slot       = cre_pkg::SLOTF_W'(r_k);
                o_res.last       = rpt_last;
            end
            default: begin
                o_item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cre_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) begin
            r_item <= i_item;
        end
        if (ok_report) begin
            r_status <= cre_pkg::ST_OK;
        end else if (fail_report) begin
            r_status <= exec_timeout ? cre_pkg::ST_TIMEOUT : cre_pkg::ST_FRAME;
        end
    end

    // slot counter shared by the frame check and the report walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (r_state == cre_pkg::S_EXEC) begin
            r_k <= '0;
        end else if ((r_state == cre_pkg::S_CHK_EV) && (ok_report || fail_report)) begin
            r_k <= '0;
        end else if ((r_state == cre_pkg::S_CHK_EV) && !fail_now) begin
            r_k <= k_inc;
        end else if ((r_state == cre_pkg::S_RPT_OUT) && i_res_ready) begin
            r_k <= k_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cre_pkg::CHANNELS; i++) begin
                r_sid[i]   <= '0;
                r_sdata[i] <= '0;
                r_sexp[i]  <= '0;
                r_rc[i]    <= '0;
                r_err[i]   <= '0;
                r_phase[i] <= cre_pkg::PH_IDLE;
            end
        end else begin
            if (exec_start) begin
                r_sid[ch_idx]   <= r_item.id;
                r_sdata[ch_idx] <= r_item.data;
                r_sexp[ch_idx]  <= exp_sat;
                r_rc[ch_idx]    <= '0;
                r_phase[ch_idx] <= cre_pkg::PH_TX;
            end
            if (exec_sent_arm) begin
                r_phase[ch_idx] <= cre_pkg::PH_RX;
            end
            if (reply_store) begin
                r_rc[ch_idx] <= rc_after;
            end
            if (fail_resend) begin
                r_err[ch_idx]   <= err_inc;
                r_rc[ch_idx]    <= '0;
                r_phase[ch_idx] <= cre_pkg::PH_TX;
            end
            if (fail_report || ok_report) begin
                r_err[ch_idx]   <= '0;
                r_phase[ch_idx] <= cre_pkg::PH_IDLE;
            end
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_item_ready) |=> (r_state == cre_pkg::S_EXEC))
        else $error("accepted request not decoded");

    a_rc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cre_pkg::S_EXEC) && ch_ok) |-> (cur_rc <= cre_pkg::CNT_W'(cur_exp)))
        else $error("reply count beyond expected count");

    a_cmd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == cre_pkg::KIND_CMD)) |-> o_res.last)
        else $error("command frame not marked last");

    a_rpt_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cre_pkg::S_RPT_OUT) |-> (r_k < rpt_n))
        else $error("report slot beyond entry count");

endmodule

`default_nettype wire
